// ----- rtl/pi3d_pkg.sv -----
// Shared constants, codes and types for the 3D polyline interpolator.
`timescale 1ns / 1ps

package pi3d_pkg;

  // Store geometry and number format
  localparam int DEPTH     = 256;
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int COORD_W = 32;
  localparam int POINT_W = 3 * COORD_W;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Datapath widths
  localparam int R_W    = COORD_W + 2;          // interpolation weight, signed
  localparam int PROD_W = 2 * COORD_W;          // magnitude product
  localparam int Q_W    = PROD_W + 1 - FRAC_BITS;
  localparam int SQ_W   = Q_W + 1;              // signed scaled product
  localparam int SUM_W  = SQ_W + 1;

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  // Request types
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_TOOFEW = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Axis being worked on by the shared datapath
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_RD0,
    S_RD1,
    S_CAP,
    S_DIFF,
    S_MUL,
    S_RND,
    S_ACC,
    S_DONE
  } seq_state_t;

endpackage

// ----- rtl/pi3d_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module pi3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule

// ----- rtl/polyline_point_interpolator_3d_core.sv -----
// Top level of the 3D polyline point store and linear interpolator.
//
// Usage: requests arrive on the in_ channel (valid/ready). An append request
// stores in_coord_x/y/z at the next free slot of a 256-entry point store; a
// query request interpolates the polyline at in_param_u (signed Q16.16).
// Every request produces exactly one result on the out_ channel, carrying
// out_x/out_y/out_z (signed Q16.16, saturated) and out_status.
// Timing: one request at a time; in_ready is high only while the sequencer
// is idle. An append goes straight to loading the output register. A query
// passes set-up and, if it ends in an error status, goes to that step too; a
// successful query makes two reads of the single-port store and a capture,
// then per axis, through one shared 32x32 multiplier, takes the difference,
// multiplies, rounds, and adds and saturates, and then loads the output
// register. in_ready returns with the result.
// A finished result waits in the output register; while it waits the block
// already takes the next request, and it only holds in its final step if a
// second result is ready before the first has been taken.
// Reset: rst_n is synchronous and active low. It empties the store (the
// point count returns to zero) and drops out_valid; the store contents are
// not cleared, as only entries below the count are ever read.
`timescale 1ns / 1ps

module polyline_point_interpolator_3d_core
  import pi3d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic signed [COORD_W-1:0] in_param_u,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic [1:0]                out_status
);

  localparam int S_W = COORD_W - FRAC_BITS;
  localparam logic signed [COORD_W-1:0] NEG_ONE = COORD_W'(-ONE);
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

  // Sequencer and control state
  seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic out_valid_r, out_valid_nxt;

  // Request and working registers
  logic signed [COORD_W-1:0] u_r, u_nxt;
  logic [ADDR_W-1:0] i0_r, i0_nxt, i1_r, i1_nxt;
  logic signed [R_W-1:0] r_r, r_nxt;
  logic [COORD_W-1:0] rmag_r, rmag_nxt;
  logic rneg_r, rneg_nxt;
  logic [POINT_W-1:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic [COORD_W-1:0] dmag_r, dmag_nxt;
  logic pneg_r, pneg_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SQ_W-1:0] sq_r, sq_nxt;
  logic [COORD_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt, res_z_r, res_z_nxt;
  logic [1:0] status_r, status_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  // Point store port
  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [POINT_W-1:0] ram_wdata, ram_rdata;

  pi3d_ram #(
    .WIDTH(POINT_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .addr   (ram_addr),
    .wr_data(ram_wdata),
    .rd_data(ram_rdata)
  );

  assign ram_wdata = {in_coord_x, in_coord_y, in_coord_z};

  // Segment selection from the query parameter. The integer part is
  // truncated toward zero, so any u strictly between -1 and 0 stays on the
  // first segment with a negative weight.
  logic before_start, on_segment, few_points;
  logic [S_W-1:0] s_idx;
  logic [COORD_W-1:0] s_ext, s_inc, cnt_ext;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic [R_W-1:0] last_off;
  logic signed [R_W-1:0] r_inside, r_before, r_past;

  assign before_start = (u_r <= NEG_ONE);
  assign s_idx        = u_r[COORD_W-1] ? '0 : u_r[COORD_W-1:FRAC_BITS];
  assign s_ext        = COORD_W'(s_idx);
  assign s_inc        = s_ext + COORD_W'(1);
  assign cnt_ext      = COORD_W'(count_r);
  assign on_segment   = !before_start && (s_ext < cnt_ext);
  assign few_points   = (count_r < CNT_W'(2));
  assign cnt_m1       = count_r - CNT_W'(1);
  assign cnt_m2       = count_r - CNT_W'(2);
  assign last_off     = R_W'(cnt_m1) << FRAC_BITS;

  assign r_inside = u_r[COORD_W-1] ? R_W'(u_r) : $signed(R_W'(u_r[FRAC_BITS-1:0]));
  assign r_before = R_W'(ONE) - R_W'(u_r);
  assign r_past   = R_W'(u_r) - $signed(last_off);

  // Shared arithmetic datapath, one axis at a time
  logic [COORD_W-1:0] p0_ax, p1_ax;
  logic [COORD_W:0] d_w, d_abs;
  logic [R_W-1:0] r_abs;
  logic [PROD_W-1:0] prod_w;
  logic [PROD_W:0] rnd_w;
  logic [Q_W-1:0] q_w;
  logic signed [SUM_W-1:0] sum_w;
  logic [SUM_W-COORD_W:0] sum_hi;
  logic [COORD_W-1:0] sat_w;

  always_comb begin
    case (axis_r)
      AXIS_X: begin
        p0_ax = p0_r[POINT_W-1 -: COORD_W];
        p1_ax = p1_r[POINT_W-1 -: COORD_W];
      end
      AXIS_Y: begin
        p0_ax = p0_r[2*COORD_W-1 -: COORD_W];
        p1_ax = p1_r[2*COORD_W-1 -: COORD_W];
      end
      default: begin
        p0_ax = p0_r[COORD_W-1:0];
        p1_ax = p1_r[COORD_W-1:0];
      end
    endcase
  end

  assign r_abs  = r_r[R_W-1] ? (~r_r + R_W'(1)) : r_r;
  assign d_w    = {p1_ax[COORD_W-1], p1_ax} - {p0_ax[COORD_W-1], p0_ax};
  assign d_abs  = d_w[COORD_W] ? (~d_w + (COORD_W + 1)'(1)) : d_w;
  assign prod_w = {{COORD_W{1'b0}}, dmag_r} * {{COORD_W{1'b0}}, rmag_r};
  assign rnd_w  = {1'b0, prod_r} + HALF;
  assign q_w    = rnd_w[PROD_W:FRAC_BITS];
  assign sum_w  = SUM_W'($signed(p0_ax)) + SUM_W'(sq_r);
  assign sum_hi = sum_w[SUM_W-1:COORD_W-1];
  assign sat_w  = ((&sum_hi) || !(|sum_hi)) ? sum_w[COORD_W-1:0]
                : (sum_w[SUM_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r          <= u_nxt;
    i0_r         <= i0_nxt;
    i1_r         <= i1_nxt;
    r_r          <= r_nxt;
    rmag_r       <= rmag_nxt;
    rneg_r       <= rneg_nxt;
    p0_r         <= p0_nxt;
    p1_r         <= p1_nxt;
    dmag_r       <= dmag_nxt;
    pneg_r       <= pneg_nxt;
    prod_r       <= prod_nxt;
    sq_r         <= sq_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_z_r      <= res_z_nxt;
    status_r     <= status_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_z_r      <= out_z_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    axis_nxt       = axis_r;
    out_valid_nxt  = out_valid_r;
    u_nxt          = u_r;
    i0_nxt         = i0_r;
    i1_nxt         = i1_r;
    r_nxt          = r_r;
    rmag_nxt       = rmag_r;
    rneg_nxt       = rneg_r;
    p0_nxt         = p0_r;
    p1_nxt         = p1_r;
    dmag_nxt       = dmag_r;
    pneg_nxt       = pneg_r;
    prod_nxt       = prod_r;
    sq_nxt         = sq_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_z_nxt      = res_z_r;
    status_nxt     = status_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_z_nxt      = out_z_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_addr       = i0_r;
    in_ready       = (state_r == S_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        ram_addr = count_r[ADDR_W-1:0];
        if (in_valid) begin
          res_x_nxt = '0;
          res_y_nxt = '0;
          res_z_nxt = '0;
          if (in_req_type == REQ_APPEND) begin
            if (count_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = ST_OK;
            end
            state_nxt = S_DONE;
          end else begin
            u_nxt     = in_param_u;
            state_nxt = S_SETUP;
          end
        end
      end

      S_SETUP: begin
        status_nxt = ST_OK;
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end else if (on_segment) begin
          i0_nxt    = s_idx[ADDR_W-1:0];
          i1_nxt    = (s_inc == cnt_ext) ? '0 : s_inc[ADDR_W-1:0];
          r_nxt     = r_inside;
          state_nxt = S_RD0;
        end else if (few_points) begin
          status_nxt = ST_TOOFEW;
          state_nxt  = S_DONE;
        end else if (before_start) begin
          i0_nxt    = ADDR_W'(1);
          i1_nxt    = '0;
          r_nxt     = r_before;
          state_nxt = S_RD0;
        end else begin
          i0_nxt    = cnt_m2[ADDR_W-1:0];
          i1_nxt    = cnt_m1[ADDR_W-1:0];
          r_nxt     = r_past;
          state_nxt = S_RD0;
        end
      end

      S_RD0: begin
        ram_addr  = i0_r;
        rmag_nxt  = r_abs[COORD_W-1:0];
        rneg_nxt  = r_r[R_W-1];
        state_nxt = S_RD1;
      end

      S_RD1: begin
        ram_addr  = i1_r;
        p0_nxt    = ram_rdata;
        state_nxt = S_CAP;
      end

      S_CAP: begin
        p1_nxt    = ram_rdata;
        axis_nxt  = AXIS_X;
        state_nxt = S_DIFF;
      end

      S_DIFF: begin
        dmag_nxt  = d_abs[COORD_W-1:0];
        pneg_nxt  = rneg_r ^ d_w[COORD_W];
        state_nxt = S_MUL;
      end

      S_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = S_RND;
      end

      S_RND: begin
        sq_nxt    = pneg_r ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
        state_nxt = S_ACC;
      end

      S_ACC: begin
        case (axis_r)
          AXIS_X:  res_x_nxt = sat_w;
          AXIS_Y:  res_y_nxt = sat_w;
          default: res_z_nxt = sat_w;
        endcase
        if (axis_r == AXIS_Z) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DIFF;
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
          out_z_nxt      = res_z_r;
          out_status_nxt = status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

endmodule
